FILE: src/seam_cumulative_energy_core_macros.svh
// ----------------------------------------------------------------------------
// Seam cumulative energy core assertion macros
// Shared concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef SEAM_CUMULATIVE_ENERGY_CORE_MACROS_SVH
`define SEAM_CUMULATIVE_ENERGY_CORE_MACROS_SVH

// same-cycle implication; the consequent may begin with its own ## delay
`define SCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("sce assertion failed");

// next-cycle implication
`define SCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("sce assertion failed");

`endif

FILE: src/sce_pkg.sv
// ----------------------------------------------------------------------------
// Seam cumulative energy package
// Field widths and bus packing constants of the cumulative energy core.
// ----------------------------------------------------------------------------
package sce_pkg;

    localparam int PIXEL_W     = 8;
    localparam int ENERGY_W    = 20;
    localparam int COL_W       = 11;
    localparam int CFG_W       = 12;
    localparam int CFG_RESET   = 2048;

    localparam int IN_TDATA_W  = ((PIXEL_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = ENERGY_W + COL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

endpackage

FILE: src/seam_cumulative_energy_core.sv
// ----------------------------------------------------------------------------
// Seam cumulative energy core
// Seam-carving cumulative energy map over a pixel energy stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries pixel energies in raster order, bottom row
//   first, left to right; tuser marks the first pixel of a new image.
//   Master stream m_axis returns one transaction per pixel: the saturated
//   cumulative energy and its column, tlast on the last pixel of a row.
//   The row width is written through the cfg channel (always ready) while
//   the block is idle; zero counts as one, widths above MAX_WIDTH clip.
//   A pixel passes the working stage and the output register to m_axis,
//   and one pixel is taken every cycle while m_axis does not stall. The
//   previous row lives in a dual-read line store read at the pixel's
//   column and the one to its right; a result being written is forwarded
//   to a read of the same entry. Reset clears the control state and the
//   row width returns to 2048; the line store is not cleared, the first
//   row never reads it. When m_axis stalls, the output register and one
//   working stage fill, then s_axis tready drops.
// ----------------------------------------------------------------------------
module seam_cumulative_energy_core #(
    parameter int MAX_WIDTH = 2048,
    parameter int SUM_BITS  = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sce_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // pixel_energy
    input  logic                            s_axis_tuser,  // frame_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sce_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // cumulative_energy, column
    output logic                            m_axis_tlast,  // row_end
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sce_pkg::CFG_W-1:0]       i_cfg_data     // row_width
);
    import sce_pkg::*;

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int WB     = $clog2(MAX_WIDTH + 1);
    localparam int WW     = (WB > CFG_W) ? WB : CFG_W;
    localparam int W_INIT = (CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET;

    logic [SUM_BITS-1:0] r_mem [MAX_WIDTH];

    logic [WW-1:0]       r_width;
    logic [WW-1:0]       cfg_ext;
    logic [WW-1:0]       n_width;

    logic [AW-1:0]       r_col;
    logic                r_first;
    logic                in_acc;
    logic                start;
    logic [AW-1:0]       c_eff;
    logic [WW-1:0]       c_plus1;
    logic                in_last;
    logic                in_first;
    logic [AW-1:0]       rd_mid_addr;
    logic [AW-1:0]       rd_right_addr;

    logic                r_a_valid;
    logic [PIXEL_W-1:0]  r_a_energy;
    logic [AW-1:0]       r_a_col;
    logic                r_a_first;
    logic                r_a_last;
    logic [SUM_BITS-1:0] r_rd_mid;
    logic [SUM_BITS-1:0] r_rd_right;
    logic                r_fwd_mid;
    logic                r_fwd_right;
    logic [SUM_BITS-1:0] r_fwd_val;
    logic [SUM_BITS-1:0] r_left;
    logic                a_adv;

    logic [SUM_BITS-1:0] mid;
    logic [SUM_BITS-1:0] right;
    logic [SUM_BITS-1:0] best;
    logic [SUM_BITS:0]   sum;
    logic [SUM_BITS-1:0] result;

    logic                r_out_valid;
    logic [ENERGY_W-1:0] r_out_energy;
    logic [COL_W-1:0]    r_out_col;
    logic                r_out_last;

    // configuration
    assign o_cfg_ready = 1'b1;
    assign cfg_ext     = WW'(i_cfg_data);

    always_comb begin
        if (cfg_ext == '0) begin
            n_width = WW'(1);
        end else if (cfg_ext > WW'(MAX_WIDTH)) begin
            n_width = WW'(MAX_WIDTH);
        end else begin
            n_width = cfg_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WW'(W_INIT);
        end else if (i_cfg_valid) begin
            r_width <= n_width;
        end
    end

    // column tracking at input
    assign a_adv         = r_a_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_a_valid || a_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign start         = s_axis_tuser;
    assign c_eff         = (start || (WW'(r_col) >= r_width)) ? '0 : r_col;
    assign c_plus1       = WW'(c_eff) + WW'(1);
    assign in_last       = (c_plus1 == r_width);
    assign in_first      = start || r_first;
    assign rd_mid_addr   = c_eff;
    assign rd_right_addr = in_last ? '0 : c_plus1[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
        end else if (in_acc) begin
            r_col   <= in_last ? '0 : c_plus1[AW-1:0];
            r_first <= in_last ? 1'b0 : in_first;
        end
    end

    // line store: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_mem[r_a_col] <= result;
        end
        if (in_acc) begin
            r_rd_mid   <= r_mem[rd_mid_addr];
            r_rd_right <= r_mem[rd_right_addr];
        end
    end

    // working stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_energy  <= s_axis_tdata[PIXEL_W-1:0];
            r_a_col     <= c_eff;
            r_a_first   <= in_first;
            r_a_last    <= in_last;
            r_fwd_mid   <= a_adv && (rd_mid_addr == r_a_col);
            r_fwd_right <= a_adv && (rd_right_addr == r_a_col);
            r_fwd_val   <= result;
        end
        if (a_adv) begin
            r_left <= mid;
        end
    end

    assign mid   = r_fwd_mid ? r_fwd_val : r_rd_mid;
    assign right = r_fwd_right ? r_fwd_val : r_rd_right;

    always_comb begin
        best = mid;
        if ((r_a_col != '0) && (r_left < best)) begin
            best = r_left;
        end
        if (!r_a_last && (right < best)) begin
            best = right;
        end
        if (r_a_first) begin
            sum = (SUM_BITS + 1)'(r_a_energy);
        end else begin
            sum = (SUM_BITS + 1)'(r_a_energy) + (SUM_BITS + 1)'(best);
        end
        result = sum[SUM_BITS] ? {SUM_BITS{1'b1}} : sum[SUM_BITS-1:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_out_energy <= ENERGY_W'(result);
            r_out_col    <= COL_W'(r_a_col);
            r_out_last   <= r_a_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_col, r_out_energy};
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: src/sce_checker.sv
// ----------------------------------------------------------------------------
// Seam cumulative energy checker
// Port-level assertions on the cumulative energy core, bound to the top.
// ----------------------------------------------------------------------------
`include "seam_cumulative_energy_core_macros.svh"

module sce_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sce_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // cumulative_energy, column
    input logic                            m_axis_tlast   // row_end
);
    import sce_pkg::*;

    logic                 r_after_last;
    logic                 s_xfer;
    logic                 m_xfer;
    logic                 out_stall;
    logic [OUT_TDATA_W:0] out_word;
    logic [COL_W-1:0]     out_col;

    assign s_xfer    = s_axis_tvalid && s_axis_tready;
    assign m_xfer    = m_axis_tvalid && m_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tlast, m_axis_tdata};
    assign out_col   = m_axis_tdata[ENERGY_W +: COL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_last <= 1'b1;
        end else if (m_xfer) begin
            r_after_last <= m_axis_tlast;
        end
    end

    // a transaction after a row end starts at column zero
    `SCE_ASSERT_IMP(a_row_restart, i_clk, i_rst_n, m_xfer && r_after_last, (out_col == '0))

    // after an accepted pixel passes the working stage, the output is valid
    `SCE_ASSERT_IMP(a_latency, i_clk, i_rst_n, s_xfer, ##2 m_axis_tvalid)

    // input is never held off while the output is empty
    `SCE_ASSERT_IMP(a_no_idle_block, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

    // stalled output transaction holds
    `SCE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, (m_axis_tvalid && $stable(out_word)))

endmodule

bind seam_cumulative_energy_core sce_checker u_sce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seam cumulative energy core testbench
// Streams pixel energies through the core under several row widths and
// stall patterns, predicts every cumulative energy, column and row end, and
// compares each output transaction in order against the prediction.
// ----------------------------------------------------------------------------
module testbench;
    import sce_pkg::*;

    localparam int          MAX_COLS   = 2048;
    localparam int          LIMIT      = 500000;
    localparam logic [20:0] ENERGY_MAX = 21'h0FFFFF;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [COL_W-1:0]    column;
        logic                row_end;
    } t_map_point;

    class t_energy_map_board;
        logic [ENERGY_W-1:0] prev_row[MAX_COLS];
        bit                  written[MAX_COLS];
        int unsigned         col;
        bit                  first_row;
        logic [ENERGY_W-1:0] left_held;
        logic [CFG_W-1:0]    width_reg;
        t_map_point          pending[$];
        int                  errors;

        function new();
            col       = 0;
            first_row = 1'b1;
            left_held = '0;
            width_reg = CFG_W'(CFG_RESET);
            errors    = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_width(logic [CFG_W-1:0] v);
            width_reg = v;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_COLS) return MAX_COLS;
            return width_reg;
        endfunction

        // true when a pixel without frame start would read a line entry
        // that was never written
        function bit start_needed();
            int unsigned w;
            int unsigned c;
            w = eff_width();
            c = (col >= w) ? 0 : col;
            if (first_row) return 1'b0;
            if (!written[c]) return 1'b1;
            if (c + 1 < w && !written[c + 1]) return 1'b1;
            return 1'b0;
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] e, logic st);
            int unsigned         w;
            int unsigned         c;
            logic [ENERGY_W-1:0] mid;
            logic [ENERGY_W-1:0] best;
            logic [20:0]         sum;
            t_map_point          r;
            w = eff_width();
            if (st) begin
                col       = 0;
                first_row = 1'b1;
                left_held = '0;
            end
            if (col >= w) begin
                col       = 0;
                left_held = '0;
            end
            c   = col;
            mid = prev_row[c];
            if (first_row) begin
                sum = {13'd0, e};
            end else begin
                best = mid;
                if (c > 0 && left_held < best) best = left_held;
                if (c + 1 < w && prev_row[c + 1] < best) best = prev_row[c + 1];
                sum = {13'd0, e} + {1'b0, best};
            end
            if (sum > ENERGY_MAX) sum = ENERGY_MAX;
            left_held   = mid;
            prev_row[c] = sum[ENERGY_W-1:0];
            written[c]  = 1'b1;
            r.energy  = sum[ENERGY_W-1:0];
            r.column  = c[COL_W-1:0];
            r.row_end = (c + 1 == w);
            pending.push_back(r);
            if (r.row_end) begin
                col       = 0;
                first_row = 1'b0;
                left_held = '0;
            end else begin
                col = c + 1;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic last);
            t_map_point want;
            if (pending.size() == 0) begin
                $error("unexpected result transaction: tdata %0h tlast %0b", data, last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data[ENERGY_W-1:0] !== want.energy) begin
                $error("cumulative_energy: expected %0d, got %0d",
                       want.energy, data[ENERGY_W-1:0]);
                errors++;
            end
            if (data[ENERGY_W +: COL_W] !== want.column) begin
                $error("column: expected %0d, got %0d", want.column, data[ENERGY_W +: COL_W]);
                errors++;
            end
            if (last !== want.row_end) begin
                $error("row_end: expected %0b, got %0b", want.row_end, last);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    t_energy_map_board board;
    int                sender_idle_pct = 31;
    int                receiver_idle_pct = 64;
    int unsigned       cycles = 0;

    seam_cumulative_energy_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tlast);
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] e, input logic st);
        logic st_eff;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        st_eff = st | board.start_needed();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= e;
        s_axis_tuser  <= st_eff;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_pixel(e, st_eff);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_width(v);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [PIXEL_W-1:0] pick_energy();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return PIXEL_W'($urandom_range(0, 255));
    endfunction

    task automatic run_random_frames(input int unsigned n_items);
        int unsigned      done;
        int unsigned      r;
        int unsigned      len;
        logic [CFG_W-1:0] w;
        done = 0;
        while (done < n_items) begin
            r = $urandom_range(0, 9);
            if (r == 0) w = '0;
            else if (r == 1) w = CFG_W'($urandom_range(40, 120));
            else w = CFG_W'($urandom_range(1, 24));
            write_width(w);
            len = ((w == 0) ? 1 : w) * 3 + $urandom_range(10, 60);
            for (int i = 0; i < len; i++)
                send_pixel(pick_energy(), (i == 0) ? logic'($urandom_range(0, 1))
                                                   : ($urandom_range(0, 39) == 0));
            done += len;
        end
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset width: columns count up in the bottom row
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd128, 1'b0);
        // shrink below the running column, then three rows of three
        write_width(12'd3);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b0);
        repeat (3) send_pixel(8'd255, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd2, 1'b0);
        send_pixel(8'd3, 1'b0);
        // new image mid-row
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd9, 1'b1);
        send_pixel(8'd4, 1'b0);
        // single column, then zero width acting as one
        write_width(12'd1);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd100, 1'b0);
        send_pixel(8'd50, 1'b0);
        write_width(12'd0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);

        run_random_frames(380);
        // oversized width clips to the full line
        write_width(12'd4095);
        for (int i = 0; i < 100; i++) send_pixel(pick_energy(), i == 0);

        sender_idle_pct   = 64;
        receiver_idle_pct = 31;
        run_random_frames(380);
        // one column of full energy accumulates row by row
        write_width(12'd1);
        for (int i = 0; i < 60; i++)
            send_pixel((i < 50) ? 8'd255 : pick_energy(), i == 0);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random_frames(380);
        write_width(12'd2048);
        for (int i = 0; i < 40; i++) send_pixel(pick_energy(), 1'b0);

        wait_drained();
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+src
src/sce_pkg.sv
src/seam_cumulative_energy_core.sv
src/sce_checker.sv
tb/testbench.sv
